### design/text_console_with_scrollback_defines.svh
// Assertion macros used by the checker.
`ifndef TEXT_CONSOLE_WITH_SCROLLBACK_DEFINES_SVH
`define TEXT_CONSOLE_WITH_SCROLLBACK_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants of the text console with scrollback.
// ----------------------------------------------------------------------------
`default_nettype none
package tcs_pkg;
  localparam int unsigned MaxCols      = 128;
  localparam int unsigned MaxRows      = 64;
  localparam int unsigned HistoryLines = 128;

  localparam logic [7:0] ResetColumns = 8'd80;
  localparam logic [6:0] ResetRows    = 7'd25;
  localparam logic [7:0] ResetColor   = 8'd7;

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChBack    = 8'h08;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChReturn  = 8'h0d;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    OpPut  = 2'd0,
    OpRead = 2'd1,
    OpUp   = 2'd2,
    OpDown = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegColumns = 2'd0,
    RegRows    = 2'd1,
    RegColor   = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    StClear,    // sweep memories after reset
    StIdle,
    StPut,      // decode a put character
    StPlain,    // write one space/char, then settle
    StSettle,
    StScrRd,    // issue read of source cell
    StScrWr,    // write moved cell
    StScrClr,   // clear the bottom row
    StRdWait,
    StRdOut,
    StOut
  } state_e;
endpackage
`default_nettype wire

### design/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/text_console_with_scrollback.sv
// ----------------------------------------------------------------------------
// text_console_with_scrollback
// Character/attribute grid console with cursor and a ring of scrolled lines.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload (lsb first)
// s_axis      in   opcode[1:0] char_code[9:2] cell_col[16:10] cell_row[22:17]
// m_axis      out  cell_char, cell_color, cursor_col, cursor_row, view_offset,
//                  viewing, scrolled
// cfg         in   we, index, 8-bit data
// A put decodes the byte, writes each space or character, then settles; a
// scroll copies the top row to history, moves each active row up and clears
// the bottom row. After reset a clearing pass over the memories runs first.
// Input is ready whenever the sequencer idles; a result not yet taken holds
// the next item at its last step.
`default_nettype none
module text_console_with_scrollback #(
  parameter int unsigned MaxCols      = tcs_pkg::MaxCols,
  parameter int unsigned MaxRows      = tcs_pkg::MaxRows,
  parameter int unsigned HistoryLines = tcs_pkg::HistoryLines
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // opcode, char_code, cell_col, cell_row
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_char, cell_color, cursor_col, cursor_row, view_offset, viewing, scrolled
  output logic      [39:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  localparam int unsigned CW = $clog2(MaxCols);
  localparam int unsigned RW = $clog2(MaxRows);
  localparam int unsigned HW = $clog2(HistoryLines);
  localparam int unsigned SA = CW + RW;
  localparam int unsigned HA = CW + HW;
  localparam int unsigned CA = (SA > HA) ? SA : HA;
  localparam int unsigned NW = CW + 1;  // count up to MaxCols
  localparam int unsigned MW = RW + 1;
  localparam int unsigned KW = HW + 1;

  // configuration
  logic [7:0] cols_reg_q, color_q;
  logic [6:0] rows_reg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_reg_q <= tcs_pkg::ResetColumns;
      rows_reg_q <= tcs_pkg::ResetRows;
      color_q    <= tcs_pkg::ResetColor;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcs_pkg::RegColumns: cols_reg_q <= cfg_data_i;
        tcs_pkg::RegRows:    rows_reg_q <= cfg_data_i[6:0];
        tcs_pkg::RegColor:   color_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped extents
  logic [NW-1:0] ncols;
  logic [MW-1:0] nrows;
  always_comb begin
    if (cols_reg_q == 8'd0) ncols = NW'(1);
    else if (32'(cols_reg_q) > MaxCols) ncols = NW'(MaxCols);
    else ncols = NW'(cols_reg_q);
    if (rows_reg_q == 7'd0) nrows = MW'(1);
    else if (32'(rows_reg_q) > MaxRows) nrows = MW'(MaxRows);
    else nrows = MW'(rows_reg_q);
  end

  tcs_pkg::state_e st_q, st_d;
  logic [CA-1:0] clr_q, clr_d;
  logic [CW-1:0] col_q, col_d;  // cursor
  logic [RW:0]   row_q, row_d;
  logic [HW-1:0] hstart_q, hstart_d;
  logic [KW-1:0] hcount_q, hcount_d;
  logic [KW-1:0] vdepth_q, vdepth_d;
  logic          vmode_q, vmode_d, scr_q, scr_d;
  logic [2:0]    tabn_q, tabn_d;
  logic [7:0]    pch_q, pch_d;
  logic [CW-1:0] sx_q, sx_d;    // scroll column
  logic [RW-1:0] sy_q, sy_d;    // scroll source row
  logic [7:0]    ich_q;
  logic [CW-1:0] icx_q;
  logic [RW-1:0] icy_q;
  logic          rhist_q, rhist_d, rspace_q, rspace_d, rnone_q, rnone_d;
  logic [7:0]    och_q, och_d, oco_q, oco_d;
  logic          ovalid_q, ovalid_d;
  logic [39:0]   res_q, res_d;

  // memory ports
  logic          sc_we, so_we, h_we;
  logic [SA-1:0] s_wa, s_ra;
  logic [7:0]    sc_wd, so_wd, sc_rd, so_rd, h_wd, h_rd;
  logic [HA-1:0] h_wa, h_ra;

  tcs_ram #(.Width(8), .Depth(MaxCols*MaxRows)) u_chars (
    .clk_i, .we_i(sc_we), .waddr_i(s_wa), .wdata_i(sc_wd), .raddr_i(s_ra), .rdata_o(sc_rd));
  tcs_ram #(.Width(8), .Depth(MaxCols*MaxRows)) u_colors (
    .clk_i, .we_i(so_we), .waddr_i(s_wa), .wdata_i(so_wd), .raddr_i(s_ra), .rdata_o(so_rd));
  tcs_ram #(.Width(8), .Depth(MaxCols*HistoryLines)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd));

  logic accept;
  assign s_axis_tready = (st_q == tcs_pkg::StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tcs_pkg::StClear; clr_q <= '0; col_q <= '0; row_q <= '0;
      hstart_q <= '0; hcount_q <= '0; vdepth_q <= '0; vmode_q <= 1'b0;
      scr_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; col_q <= col_d; row_q <= row_d;
      hstart_q <= hstart_d; hcount_q <= hcount_d; vdepth_q <= vdepth_d;
      vmode_q <= vmode_d; scr_q <= scr_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tabn_q <= tabn_d; pch_q <= pch_d; sx_q <= sx_d; sy_q <= sy_d;
    rhist_q <= rhist_d; rspace_q <= rspace_d; rnone_q <= rnone_d;
    och_q <= och_d; oco_q <= oco_d; res_q <= res_d;
    if (accept) begin
      ich_q <= s_axis_tdata[9:2];
      icx_q <= CW'(s_axis_tdata[16:10]);
      icy_q <= RW'(s_axis_tdata[22:17]);
    end
  end

  logic [KW-1:0] tail;
  logic [31:0]   idx;
  logic [31:0]   lsum;
  always_comb begin
    tail = KW'(({1'b0, hstart_q} + hcount_q) % HistoryLines);
    // history row index while viewing
    idx  = 32'(hcount_q) - 32'(vdepth_q) - (32'(nrows) - 32'd1 - 32'(icy_q));
    lsum = 32'(hstart_q) + idx;
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; col_d = col_q; row_d = row_q;
    hstart_d = hstart_q; hcount_d = hcount_q; vdepth_d = vdepth_q; vmode_d = vmode_q;
    scr_d = scr_q; ovalid_d = ovalid_q; tabn_d = tabn_q; pch_d = pch_q;
    sx_d = sx_q; sy_d = sy_q; rhist_d = rhist_q; rspace_d = rspace_q;
    rnone_d = rnone_q; och_d = och_q; oco_d = oco_q; res_d = res_q;
    sc_we = 1'b0; so_we = 1'b0; h_we = 1'b0;
    s_wa = '0; s_ra = '0; h_wa = '0; h_ra = '0;
    sc_wd = '0; so_wd = '0; h_wd = '0;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (st_q)
      tcs_pkg::StClear: begin
        sc_we = 1'b1; so_we = 1'b1; h_we = 1'b1;
        s_wa = SA'(clr_q); h_wa = HA'(clr_q);
        clr_d = clr_q + 1'b1;
        if (&clr_q) st_d = tcs_pkg::StIdle;
      end
      tcs_pkg::StIdle: begin
        if (accept) begin
          scr_d = 1'b0; och_d = '0; oco_d = '0;
          case (tcs_pkg::op_e'(s_axis_tdata[1:0]))
            tcs_pkg::OpPut: st_d = tcs_pkg::StPut;
            tcs_pkg::OpRead: st_d = tcs_pkg::StRdWait;
            tcs_pkg::OpUp: begin
              if (hcount_q != '0) begin
                vmode_d = 1'b1;
                vdepth_d = (vdepth_q >= hcount_q) ? hcount_q : vdepth_q + 1'b1;
              end
              st_d = tcs_pkg::StOut;
            end
            default: begin
              if (vmode_q) begin
                if (vdepth_q <= KW'(1)) begin vdepth_d = '0; vmode_d = 1'b0; end
                else vdepth_d = vdepth_q - 1'b1;
              end
              st_d = tcs_pkg::StOut;
            end
          endcase
        end
      end
      tcs_pkg::StRdWait: begin
        // set up the address, data comes back next cycle
        rnone_d = (NW'(icx_q) >= ncols) || (MW'(icy_q) >= nrows);
        rhist_d = vmode_q;
        rspace_d = idx[31] || (idx >= 32'(hcount_q));
        s_ra = {RW'(icy_q), icx_q};
        h_ra = {HW'(lsum % HistoryLines), icx_q};
        st_d = tcs_pkg::StRdOut;
      end
      tcs_pkg::StRdOut: begin
        if (rnone_q) begin och_d = '0; oco_d = '0; end
        else if (rhist_q) begin
          oco_d = color_q;
          och_d = rspace_q ? tcs_pkg::ChSpace : h_rd;
        end else begin och_d = sc_rd; oco_d = so_rd; end
        st_d = tcs_pkg::StOut;
      end
      tcs_pkg::StPut: begin
        logic [CW-1:0] c;
        logic [RW:0]   r;
        c = (NW'(col_q) >= ncols) ? CW'(ncols - 1'b1) : col_q;
        r = ((RW+1)'(row_q) >= (RW+1)'(nrows)) ? (RW+1)'(nrows - 1'b1) : row_q;
        col_d = c; row_d = r;
        st_d = tcs_pkg::StSettle;
        case (ich_q)
          tcs_pkg::ChNewline: begin col_d = '0; row_d = r + 1'b1; end
          tcs_pkg::ChBack: begin
            if (c != '0) begin
              col_d = c - 1'b1; sc_we = 1'b1; sc_wd = tcs_pkg::ChSpace;
              s_wa = {RW'(r), CW'(c - 1'b1)};
            end else if (r != '0) begin
              col_d = CW'(ncols - 1'b1); row_d = r - 1'b1; sc_we = 1'b1;
              sc_wd = tcs_pkg::ChSpace; s_wa = {RW'(r - 1'b1), CW'(ncols - 1'b1)};
            end
          end
          tcs_pkg::ChTab: begin
            tabn_d = 3'd4 - {1'b0, c[1:0]}; pch_d = tcs_pkg::ChSpace;
            st_d = tcs_pkg::StPlain;
          end
          tcs_pkg::ChReturn: col_d = '0;
          default: begin
            tabn_d = 3'd1; pch_d = ich_q; st_d = tcs_pkg::StPlain;
          end
        endcase
      end
      tcs_pkg::StPlain: begin
        sc_we = 1'b1; sc_wd = pch_q; s_wa = {RW'(row_q), col_q};
        tabn_d = tabn_q - 1'b1;
        if (NW'(col_q) + 1'b1 >= ncols) begin col_d = '0; row_d = row_q + 1'b1; end
        else col_d = col_q + 1'b1;
        st_d = tcs_pkg::StSettle;
      end
      tcs_pkg::StSettle: begin
        if (MW'(row_q) >= nrows) begin
          // save top row then shift rows up
          sx_d = '0; sy_d = '0; scr_d = 1'b1; st_d = tcs_pkg::StScrRd;
        end else if (tabn_q != '0 && pch_q == tcs_pkg::ChSpace &&
                     ich_q == tcs_pkg::ChTab) begin
          st_d = tcs_pkg::StPlain;
        end else st_d = tcs_pkg::StOut;
      end
      tcs_pkg::StScrRd: begin
        s_ra = {sy_q, sx_q};
        st_d = tcs_pkg::StScrWr;
      end
      tcs_pkg::StScrWr: begin
        if (sy_q == '0) begin
          h_we = 1'b1; h_wa = {HW'(tail), sx_q};
          h_wd = ((CW+1)'(sx_q) < ncols) ? sc_rd : 8'd0;
        end else if ((CW+1)'(sx_q) < ncols) begin
          sc_we = 1'b1; so_we = 1'b1; sc_wd = sc_rd; so_wd = so_rd;
          s_wa = {sy_q - 1'b1, sx_q};
        end
        if (32'(sx_q) == MaxCols - 1) begin
          sx_d = '0;
          if (sy_q == '0) begin
            if (32'(hcount_q) < HistoryLines) hcount_d = hcount_q + 1'b1;
            else hstart_d = HW'((32'(hstart_q) + 1) % HistoryLines);
          end
          if ((RW+1)'(sy_q) + 1'b1 >= (RW+1)'(nrows)) begin
            st_d = tcs_pkg::StScrClr;
          end else begin
            sy_d = sy_q + 1'b1; st_d = tcs_pkg::StScrRd;
          end
        end else begin
          sx_d = sx_q + 1'b1; st_d = tcs_pkg::StScrRd;
        end
      end
      tcs_pkg::StScrClr: begin
        sc_we = (CW+1)'(sx_q) < ncols; so_we = sc_we;
        sc_wd = '0; so_wd = color_q;
        s_wa = {RW'(nrows - 1'b1), sx_q};
        if (32'(sx_q) == MaxCols - 1) begin
          sx_d = '0; row_d = row_q - 1'b1; st_d = tcs_pkg::StSettle;
        end else sx_d = sx_q + 1'b1;
      end
      tcs_pkg::StOut: begin
        // hold the finished word until the previous one is taken
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          res_d = {1'b0, scr_q, vmode_q, 8'(vdepth_q), 6'(row_q), 7'(col_q),
                   oco_q, och_q};
          st_d = tcs_pkg::StIdle;
        end
      end
      default: st_d = tcs_pkg::StIdle;
    endcase
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = res_q;
endmodule
`default_nettype wire

### design/tcs_checker.sv
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks on the console, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_with_scrollback_defines.svh"
module tcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  `TCS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "word changed while stalled")
  `TCS_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice in a row")
  `TCS_ASSERT_IMP(a_view, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[37], m_axis_tdata[36:29] == 8'd0, "offset without view mode")
endmodule
bind text_console_with_scrollback tcs_checker u_tcs_checker (.*);
`default_nettype wire
